/* hw/rtl/assert_macros.svh */
// Assertion helpers, included by tlb_page_table_mmu.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication check, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tlbmmu_pkg.sv */
// ----------------------------------------------------------------------------
// tlbmmu_pkg
// Shared constants, codes and the controller/datapath command/status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlbmmu_pkg;

  localparam int PAGES_DEF       = 64;
  localparam int TLB_ENTRIES_DEF = 16;

  localparam logic [6:0]  PAGES_IN_USE_RST = 7'd64;
  localparam logic [15:0] LFSR_SEED_RST    = 16'd44257;
  localparam logic [15:0] LFSR_TAPS        = 16'hB400;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_LOADED = 2'd2;
  localparam logic [1:0] CMD_BAD    = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_FAULT    = 3'd2;
  localparam logic [2:0] ST_RESOLVED = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;

  localparam logic CFG_PAGES_IN_USE = 1'b0;
  localparam logic CFG_LFSR_SEED    = 1'b1;

  // Controller commands toward the datapath.
  typedef struct packed {
    logic lookup;   // capture the word and start the page table read
    logic commit;   // apply the update and load the result register
  } ctl_cmd_t;

  // Datapath status toward the controller.
  typedef struct packed {
    logic busy_dummy;
  } dp_stat_t;

endpackage

/* hw/rtl/tlb_page_table_mmu.sv */
// ----------------------------------------------------------------------------
// tlb_page_table_mmu
// MMU with a fully associative TLB, a page table and LFSR replacement.
// ----------------------------------------------------------------------------
// The accepting edge captures a word together with its page table entry, and
// the next edge searches the TLB registers, commits the update and loads the
// output register, so the result is valid after that edge. The result then
// sits in the output register until taken, and the next word is accepted
// only after that, so no new word is taken while a result is held.
// Configuration writes are taken in any cycle and need the block to be idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlb_page_table_mmu #(
  parameter int PAGES       = tlbmmu_pkg::PAGES_DEF,
  parameter int TLB_ENTRIES = tlbmmu_pkg::TLB_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_page,
  input  logic [5:0]  in_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_frame_out,
  output logic [5:0]  out_fault_page,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count
);

  tlbmmu_pkg::ctl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tlbmmu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  tlbmmu_dp #(.PAGES(PAGES), .TLB_ENTRIES(TLB_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg_valid(cfg_valid),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_cmd(in_cmd),
    .in_page(in_page), .in_frame(in_frame), .out_status(out_status),
    .out_frame_out(out_frame_out), .out_fault_page(out_fault_page),
    .out_hit_count(out_hit_count), .out_miss_count(out_miss_count)
  );

  `ASSERT_NEXT(a_lookup_commit, clk, rst_n, cmd.lookup, cmd.commit, "commit must follow lookup")
  `ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_valid, "result must follow commit")
  `ASSERT_IMPL(a_no_accept_out, clk, rst_n, out_valid, !in_ready, "accept while result held")

endmodule

/* hw/rtl/tlbmmu_ctrl.sv */
// ----------------------------------------------------------------------------
// tlbmmu_ctrl
// Sequencer: accept a word, read, commit, then hold the result until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlbmmu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlbmmu_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.lookup = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r     <= S_OUT;
          out_valid_r <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/tlbmmu_dp.sv */
// ----------------------------------------------------------------------------
// tlbmmu_dp
// TLB registers, page table memory, victim LFSR, counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlbmmu_dp #(
  parameter int PAGES       = tlbmmu_pkg::PAGES_DEF,
  parameter int TLB_ENTRIES = tlbmmu_pkg::TLB_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlbmmu_pkg::ctl_cmd_t cmd,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [1:0]           in_cmd,
  input  logic [5:0]           in_page,
  input  logic [5:0]           in_frame,
  output logic [2:0]           out_status,
  output logic [5:0]           out_frame_out,
  output logic [5:0]           out_fault_page,
  output logic [31:0]          out_hit_count,
  output logic [31:0]          out_miss_count
);

  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int PW = $clog2(PAGES);
  localparam int CW = PW + 1;
  localparam int VSH = 24;
  localparam logic [24:0] VMUL = 25'(((1 << VSH) + TLB_ENTRIES - 1) / TLB_ENTRIES);

  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [5:0]             tlb_page_r  [TLB_ENTRIES];
  logic [5:0]             tlb_frame_r [TLB_ENTRIES];
  logic [PAGES-1:0]       pt_valid_r;
  logic [PAGES-1:0]       pt_dirty_r;
  logic [PAGES-1:0]       pt_req_r;
  logic [5:0]             pt_frame_mem [PAGES];
  logic [5:0]             pt_rd_r;
  logic                   pt_vld_r;

  logic        waiting_r, pend_write_r;
  logic [5:0]  pend_page_r;
  logic [15:0] lfsr_r;
  logic [31:0] hits_r, misses_r;
  logic [6:0]  piu_r;
  logic [1:0]  cmd_r;
  logic [5:0]  page_r, frame_r;

  logic [2:0] status_r;
  logic [5:0] fout_r, fpage_r;

  logic            hit;
  logic [5:0]      hit_frame;
  logic            have_free;
  logic [TW-1:0]   free_idx, victim, fill_idx;
  logic [15:0]     lfsr_step;
  logic [39:0]     vprod;
  logic [15:0]     vquo, vrem;
  logic [CW-1:0]   limit;
  logic            in_range, fill;
  logic [5:0]      fill_frame;
  logic [PW-1:0]   pidx;

  assign pidx = PW'(page_r);
  assign limit = ({{(CW > 7 ? CW-7 : 0){1'b0}}, piu_r} > CW'(PAGES)) ? CW'(PAGES)
                 : CW'(piu_r);
  assign in_range = ({{(CW > 6 ? CW-6 : 0){1'b0}}, page_r} < limit) &&
                    (32'(page_r) < PAGES);

  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!hit && tlb_valid_r[i] && tlb_page_r[i] == page_r) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_r[i];
      end
    end
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = TLB_ENTRIES-1; i >= 0; i--) begin
      if (!tlb_valid_r[i]) begin
        have_free = 1'b1;
        free_idx  = TW'(i);
      end
    end
  end

  assign lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ tlbmmu_pkg::LFSR_TAPS) : (lfsr_r >> 1);

  // The victim is the stepped LFSR modulo the TLB size, taken by multiplying
  // with a constant reciprocal; the quotient is exact for any 16-bit value.
  assign vprod     = 40'(lfsr_step) * 40'(VMUL);
  assign vquo      = vprod[VSH+15:VSH];
  assign vrem      = lfsr_step - vquo * 16'(TLB_ENTRIES);
  assign victim    = TW'(vrem);
  assign fill_idx  = have_free ? free_idx : victim;

  // Decide the outcome for the captured word.
  logic [2:0] st;
  logic [5:0] fo, fp;
  always_comb begin
    st = tlbmmu_pkg::ST_REJECT; fo = '0; fp = '0; fill = 1'b0; fill_frame = '0;
    if (cmd_r == tlbmmu_pkg::CMD_BAD || !in_range) begin
      st = tlbmmu_pkg::ST_REJECT;
    end else if (cmd_r == tlbmmu_pkg::CMD_LOADED) begin
      if (waiting_r && page_r == pend_page_r) begin
        st = tlbmmu_pkg::ST_RESOLVED; fo = frame_r; fill = 1'b1; fill_frame = frame_r;
      end
    end else if (!waiting_r) begin
      if (hit) begin
        st = tlbmmu_pkg::ST_HIT; fo = hit_frame;
      end else if (pt_vld_r) begin
        st = tlbmmu_pkg::ST_MISS; fo = pt_rd_r; fill = 1'b1; fill_frame = pt_rd_r;
      end else begin
        st = tlbmmu_pkg::ST_FAULT; fp = page_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      cmd_r    <= in_cmd;
      page_r   <= in_page;
      frame_r  <= in_frame;
      pt_rd_r  <= pt_frame_mem[PW'(in_page)];
      pt_vld_r <= pt_valid_r[PW'(in_page)];
    end
    if (cmd.commit) begin
      status_r <= st;
      fout_r   <= fo;
      fpage_r  <= fp;
      if (st == tlbmmu_pkg::ST_RESOLVED) pt_frame_mem[pidx] <= frame_r;
      if (fill) begin
        tlb_page_r[fill_idx]  <= page_r;
        tlb_frame_r[fill_idx] <= fill_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_valid_r  <= '0;
      pt_valid_r   <= '0;
      pt_dirty_r   <= '0;
      pt_req_r     <= '0;
      waiting_r    <= 1'b0;
      pend_page_r  <= '0;
      pend_write_r <= 1'b0;
      lfsr_r       <= tlbmmu_pkg::LFSR_SEED_RST;
      hits_r       <= '0;
      misses_r     <= '0;
      piu_r        <= tlbmmu_pkg::PAGES_IN_USE_RST;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == tlbmmu_pkg::CFG_PAGES_IN_USE) piu_r <= cfg_data[6:0];
        else lfsr_r <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
      end
      if (cmd.commit) begin
        if (fill) begin
          tlb_valid_r[fill_idx] <= 1'b1;
          if (!have_free) lfsr_r <= lfsr_step;
        end
        case (st)
          tlbmmu_pkg::ST_HIT: begin
            if (hits_r != '1) hits_r <= hits_r + 32'd1;
            if (cmd_r == tlbmmu_pkg::CMD_WRITE) pt_dirty_r[pidx] <= 1'b1;
          end
          tlbmmu_pkg::ST_MISS: begin
            if (misses_r != '1) misses_r <= misses_r + 32'd1;
            if (cmd_r == tlbmmu_pkg::CMD_WRITE) pt_dirty_r[pidx] <= 1'b1;
          end
          tlbmmu_pkg::ST_FAULT: begin
            if (misses_r != '1) misses_r <= misses_r + 32'd1;
            pt_req_r[pidx] <= 1'b1;
            waiting_r      <= 1'b1;
            pend_page_r    <= page_r;
            pend_write_r   <= (cmd_r == tlbmmu_pkg::CMD_WRITE);
          end
          tlbmmu_pkg::ST_RESOLVED: begin
            pt_valid_r[pidx] <= 1'b1;
            pt_req_r[pidx]   <= 1'b0;
            if (pend_write_r) pt_dirty_r[pidx] <= 1'b1;
            waiting_r    <= 1'b0;
            pend_write_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_status     = status_r;
  assign out_frame_out  = fout_r;
  assign out_fault_page = fpage_r;
  assign out_hit_count  = hits_r;
  assign out_miss_count = misses_r;

endmodule
